### sv/msv_pkg.sv
// Shared types and constants for the MIDI-triggered sample voice mixer.
// Depends on nothing; every other file of the block imports it.
package msv_pkg;

  // Sample store: 15-bit address, one byte per entry.
  localparam int unsigned STORE_AW    = 15;
  localparam int unsigned STORE_DEPTH = 32768;

  // Widths of the fixed fields.
  localparam int unsigned OFFSET_W    = 13;
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned VOICE_IDX_W = 3;
  localparam int unsigned NOTE_MAP_W  = 56;
  localparam int unsigned CFG_DATA_W  = 56;
  localparam int unsigned CHANNEL_W   = 5;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_MIDI   = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_LENGTH = 2'd3
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DRUM_CHANNEL = 1'b0,
    REG_NOTE_MAP     = 1'b1
  } reg_index_t;

  // MIDI status byte constants.
  localparam logic [3:0] MIDI_NOTE_ON_HI = 4'h9;

  // Voice restart request from the parser.
  typedef struct packed {
    logic                   fire;
    logic [VOICE_IDX_W-1:0] voice;
    logic [NOTE_W-1:0]      loud;
  } trigger_t;

endpackage

### sv/msv_parser.sv
// MIDI Note On parser with running status and the note-to-voice match.
// Depends on msv_pkg for the trigger struct and field widths.
module msv_parser #(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_en,
  input  logic [7:0]                        midi_byte,
  input  logic [msv_pkg::CHANNEL_W-1:0]     drum_channel,
  input  logic [msv_pkg::NOTE_MAP_W-1:0]    note_map,
  output msv_pkg::trigger_t                 trig
);
  import msv_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_NOTE = 3'b010,
    PH_VEL  = 3'b100
  } phase_t;

  phase_t                  phase;
  phase_t                  phase_next;
  logic [NOTE_W-1:0]       held_note;
  logic [CHANNEL_W-1:0]    chan;
  logic                    hit;
  logic [VOICE_IDX_W-1:0]  hit_voice;

  assign chan = {1'b0, midi_byte[3:0]} + CHANNEL_W'(1);

  // First voice, lowest index first, whose mapped note equals the held note.
  always_comb begin
    hit       = 1'b0;
    hit_voice = '0;
    for (int k = NUM_VOICES - 1; k >= 0; k--) begin
      if (note_map[NOTE_W*k +: NOTE_W] == held_note) begin
        hit       = 1'b1;
        hit_voice = VOICE_IDX_W'(k);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    if (midi_byte[7]) begin
      if (midi_byte[7:4] == MIDI_NOTE_ON_HI && chan == drum_channel) begin
        phase_next = PH_NOTE;
      end else begin
        phase_next = PH_IDLE;
      end
    end else begin
      unique case (phase)
        PH_NOTE: phase_next = PH_VEL;
        PH_VEL:  phase_next = PH_NOTE;
        default: phase_next = phase;
      endcase
    end
  end

  assign trig.fire  = byte_en && !midi_byte[7] && (phase == PH_VEL) && hit &&
                      (midi_byte[6:0] != '0);
  assign trig.voice = hit_voice;
  assign trig.loud  = midi_byte[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      held_note <= '0;
    end else if (byte_en) begin
      phase <= phase_next;
      if (!midi_byte[7] && phase == PH_NOTE) begin
        held_note <= midi_byte[6:0];
      end
    end
  end

endmodule

### sv/msv_mix.sv
// Shared mix unit: velocity-band scaling, one accumulate per step, and clipping.
// Depends on msv_pkg for the note width.
module msv_mix (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       add_en,
  input  logic [7:0]                 raw,
  input  logic [msv_pkg::NOTE_W-1:0] loud,
  output logic [7:0]                 level
);
  import msv_pkg::*;

  localparam int unsigned ACC_W = 11;

  logic [3:0]              band;
  logic [2:0]              shift_n;
  logic [8:0]              shifted;
  logic [8:0]              bias;
  logic signed [8:0]       term;
  logic signed [ACC_W-1:0] acc;

  function automatic logic signed [ACC_W-1:0] sig_127();
    return ACC_W'(127);
  endfunction

  assign band = loud[6:3];

  always_comb begin
    shift_n = 3'(band < 4'd14) + 3'(band < 4'd10) + 3'(band < 4'd6) + 3'(band < 4'd2);
    shifted = {1'b0, raw} >> shift_n;
    bias    = 9'd128 >> shift_n;
    term    = signed'(shifted - bias);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (add_en) begin
      acc <= acc + ACC_W'(term);
    end
  end

  always_comb begin
    priority if (acc < -ACC_W'(sig_127())) begin
      level = 8'd1;
    end else if (acc > ACC_W'(sig_127())) begin
      level = 8'd255;
    end else begin
      level = 8'(acc + ACC_W'(128));
    end
  end

endmodule

### sv/midi_triggered_sample_voice_mixer.sv
// Top level of the MIDI-triggered sample voice mixer: voice state, sample store,
// tick sequencer and output register. Depends on msv_pkg, msv_parser and msv_mix.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   config   | cfg_we                 | cfg_index, cfg_data
//   input    | in_valid / in_stall    | opcode, midi_byte, sample_address,
//            |                        | sample_byte, voice_select, length_value
//   output   | out_valid / out_stall  | pwm_level, active_voices
//
// MIDI bytes, sample writes and length writes finish in the cycle they are taken.
// A tick walks the voices through the one sample memory read port and the shared
// mix adder, then loads the finished mix into the output register.
// Reset is synchronous and clears the parser, the voice state and the output valid;
// the sample store has no reset and must be written before it is played.
// in_stall is high while a tick is walked or emitted, and a tick whose result finds the
// output register still full waits there until the downstream side takes it.
module midi_triggered_sample_voice_mixer #(
  parameter int unsigned NUM_VOICES  = 8,
  parameter int unsigned VOICE_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  msv_pkg::reg_index_t                cfg_index,
  input  logic [msv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  msv_pkg::opcode_t                   opcode,
  input  logic [7:0]                         midi_byte,
  input  logic [msv_pkg::STORE_AW-1:0]       sample_address,
  input  logic [7:0]                         sample_byte,
  input  logic [msv_pkg::VOICE_IDX_W-1:0]    voice_select,
  input  logic [msv_pkg::OFFSET_W-1:0]       length_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         pwm_level,
  output logic [7:0]                         active_voices
);
  import msv_pkg::*;

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned CW = $clog2(NUM_VOICES + 1);
  // Region step between voices, reduced modulo the store size.
  localparam logic [STORE_AW-1:0] DEPTH_STEP = STORE_AW'(VOICE_DEPTH % STORE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Configuration registers.
  logic [CHANNEL_W-1:0]  drum_channel;
  logic [NOTE_MAP_W-1:0] note_map;

  // Per-voice state.
  logic [NUM_VOICES-1:0] voice_playing;
  logic [OFFSET_W-1:0]   voice_offset   [NUM_VOICES];
  logic [NOTE_W-1:0]     voice_loudness [NUM_VOICES];
  logic [OFFSET_W-1:0]   voice_length   [NUM_VOICES];

  // Sample store and its registered read port.
  logic [7:0]            store [STORE_DEPTH];
  logic [7:0]            rd_data;
  logic [STORE_AW-1:0]   rd_addr;
  logic                  rd_en;

  // Tick sequencer.
  state_t                state;
  logic [CW-1:0]         cnt;
  logic [STORE_AW-1:0]   base;
  logic [VW-1:0]         cur;
  logic [OFFSET_W-1:0]   off_inc;
  logic                  fl_valid;
  logic                  fl_add;
  logic [NOTE_W-1:0]     fl_loud;
  logic [7:0]            level;

  logic                  accept;
  logic                  take_tick;
  logic                  out_free;
  trigger_t              trig;

  assign accept    = in_valid && !in_stall;
  assign take_tick = accept && (opcode == OP_TICK);
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign cur     = cnt[VW-1:0];
  assign off_inc = voice_offset[cur] + OFFSET_W'(1);
  assign rd_en   = (state == ST_WALK) && (cnt < CW'(NUM_VOICES));
  assign rd_addr = base + STORE_AW'(voice_offset[cur]);

  always_ff @(posedge clk) begin
    if (rst) begin
      drum_channel <= CHANNEL_W'(10);
      note_map     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRUM_CHANNEL: drum_channel <= cfg_data[CHANNEL_W-1:0];
        REG_NOTE_MAP:     note_map     <= cfg_data[NOTE_MAP_W-1:0];
      endcase
    end
  end

  msv_parser #(
    .NUM_VOICES (NUM_VOICES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_en      (accept && (opcode == OP_MIDI)),
    .midi_byte    (midi_byte),
    .drum_channel (drum_channel),
    .note_map     (note_map),
    .trig         (trig)
  );

  // The store is written only while idle and read only during a walk.
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_SAMPLE) begin
      store[sample_address] <= sample_byte;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // Voice state: note triggers and length writes arrive while idle; during a walk
  // each voice advances in the cycle its sample read is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_playing <= '0;
      for (int k = 0; k < NUM_VOICES; k++) begin
        voice_offset[k]   <= '0;
        voice_loudness[k] <= '0;
        voice_length[k]   <= '0;
      end
    end else begin
      if (trig.fire) begin
        voice_offset[trig.voice[VW-1:0]]   <= '0;
        voice_playing[trig.voice[VW-1:0]]  <= 1'b1;
        voice_loudness[trig.voice[VW-1:0]] <= trig.loud;
      end
      if (accept && opcode == OP_LENGTH && {1'b0, voice_select} < 4'(NUM_VOICES)) begin
        voice_length[voice_select[VW-1:0]] <= length_value;
      end
      if (rd_en && voice_playing[cur]) begin
        voice_offset[cur] <= off_inc;
        if (off_inc >= voice_length[cur]) begin
          voice_playing[cur] <= 1'b0;
        end
      end
    end
  end

  // Sequencer: one read issued per cycle, its sample summed in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      fl_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          fl_valid <= 1'b0;
          cnt      <= '0;
          if (take_tick) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          fl_valid <= rd_en;
          if (cnt == CW'(NUM_VOICES)) begin
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_EMIT: begin
          fl_valid <= 1'b0;
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      base <= '0;
    end else if (rd_en) begin
      base <= base + DEPTH_STEP;
    end
    if (rd_en) begin
      fl_add  <= voice_playing[cur];
      fl_loud <= voice_loudness[cur];
    end
  end

  msv_mix u_mix (
    .clk    (clk),
    .clear  (take_tick),
    .add_en (fl_valid && fl_add),
    .raw    (rd_data),
    .loud   (fl_loud),
    .level  (level)
  );

  // Output register: filled from the finished mix, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      pwm_level     <= level;
      active_voices <= 8'(voice_playing);
    end
  end

`ifndef SYNTH
  a_tick_starts_walk: assert property (@(posedge clk) disable iff (rst)
    take_tick |=> (state == ST_WALK) && (cnt == '0))
    else $error("tick did not start the voice walk");

  a_emit_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !fl_valid)
    else $error("sample still in flight when the mix is emitted");

  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_level != 8'd0))
    else $error("clipped level out of range");

  a_store_idle_write: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !accept)
    else $error("item accepted during a voice walk");
`endif

endmodule
